[sv/assert_macros.svh]
// assertion macros shared by the keyer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// immediate-cycle property with synchronous reset disable
`define MLK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define MLK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MLK_ASSERT(lbl, clk, rst, prop, msg)
`define MLK_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/mlk_pkg.sv]
// types, constants and the letter table of the morse letter keyer
package mlk_pkg;

   localparam int unsigned TICK_W  = 11;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [TICK_W-1:0] DOT_TICKS_RESET   = 11'd400;
   localparam logic [TICK_W-1:0] DASH_TICKS_RESET  = 11'd1100;
   localparam logic [TICK_W-1:0] PAUSE_TICKS_RESET = 11'd2000;

   localparam logic [CSR_IDX_W-1:0] CSR_DOT_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_TICKS = 2'd2;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_CHAR = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_LOW  = 8'h61; // 'a'
   localparam logic [CHAR_W-1:0] CHAR_HIGH = 8'h7A; // 'z'

   typedef struct packed {
      logic              cmd;
      logic [CHAR_W-1:0] char_code;
   } req_type;

   typedef struct packed {
      logic led_on;
      logic busy_res;
      logic char_taken;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] dot_ticks;
      logic [TICK_W-1:0] dash_ticks;
      logic [TICK_W-1:0] pause_ticks;
   } cfg_type;

   // length in [6:4], elements in [3:0], bit 0 sent first, 1 = dash
   function automatic logic [7:0] morse_entry(input logic [4:0] letter);
      logic [7:0] e;
      case (letter)
         5'd0:    e = 8'h22;
         5'd1:    e = 8'h41;
         5'd2:    e = 8'h45;
         5'd3:    e = 8'h31;
         5'd4:    e = 8'h10;
         5'd5:    e = 8'h44;
         5'd6:    e = 8'h33;
         5'd7:    e = 8'h40;
         5'd8:    e = 8'h20;
         5'd9:    e = 8'h4E;
         5'd10:   e = 8'h35;
         5'd11:   e = 8'h42;
         5'd12:   e = 8'h23;
         5'd13:   e = 8'h21;
         5'd14:   e = 8'h37;
         5'd15:   e = 8'h46;
         5'd16:   e = 8'h4B;
         5'd17:   e = 8'h32;
         5'd18:   e = 8'h30;
         5'd19:   e = 8'h11;
         5'd20:   e = 8'h34;
         5'd21:   e = 8'h48;
         5'd22:   e = 8'h36;
         5'd23:   e = 8'h49;
         5'd24:   e = 8'h4D;
         5'd25:   e = 8'h43;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

[sv/mlk_csr.sv]
// timing registers of the keyer, written through the plain csr port
module mlk_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [mlk_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mlk_pkg::TICK_W-1:0]      csr_wdata,
   output mlk_pkg::cfg_type                cfg
);

   mlk_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_ticks   <= mlk_pkg::DOT_TICKS_RESET;
         cfg_ff.dash_ticks  <= mlk_pkg::DASH_TICKS_RESET;
         cfg_ff.pause_ticks <= mlk_pkg::PAUSE_TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            mlk_pkg::CSR_DOT_TICKS:   cfg_ff.dot_ticks   <= csr_wdata;
            mlk_pkg::CSR_DASH_TICKS:  cfg_ff.dash_ticks  <= csr_wdata;
            mlk_pkg::CSR_PAUSE_TICKS: cfg_ff.pause_ticks <= csr_wdata;
            default: ; // unmapped index, ignored
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/mlk_core.sv]
// input register, keyer state update and result register
`include "assert_macros.svh"

module mlk_core #(
   parameter int unsigned MAX_ELEMENTS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  mlk_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  mlk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mlk_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_OFF   = 2'd1,
      PH_ON    = 2'd2,
      PH_PAUSE = 2'd3
   } phase_type;

   logic                        in_valid_ff;
   mlk_pkg::req_type            in_data_ff;
   logic                        out_valid_ff;
   mlk_pkg::rsp_type            out_data_ff;

   phase_type                   phase_ff,        phase_in;
   logic [MAX_ELEMENTS-1:0]     element_bits_ff, element_bits_in;
   logic [2:0]                  elements_left_ff, elements_left_in;
   logic [mlk_pkg::TICK_W-1:0]  tick_count_ff,   tick_count_in;
   logic                        led_ff,          led_in;
   logic                        taken_in;

   logic                        advance;
   logic                        req_accept;
   logic                        rsp_accept;
   logic [mlk_pkg::TICK_W-1:0]  tick_inc;
   logic [mlk_pkg::TICK_W-1:0]  duration;
   logic [7:0]                  entry;
   logic [2:0]                  left_dec;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = out_valid_ff && !rsp_stall;

   assign tick_inc = tick_count_ff + mlk_pkg::TICK_W'(1);
   assign entry    = mlk_pkg::morse_entry(5'(in_data_ff.char_code - mlk_pkg::CHAR_LOW));
   assign left_dec = (elements_left_ff != 3'd0) ? elements_left_ff - 3'd1 : 3'd0;

   always_comb begin
      if (phase_ff == PH_PAUSE) begin
         duration = cfg.pause_ticks;
      end else if (element_bits_ff[0]) begin
         duration = cfg.dash_ticks;
      end else begin
         duration = cfg.dot_ticks;
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      element_bits_in  = element_bits_ff;
      elements_left_in = elements_left_ff;
      tick_count_in    = tick_count_ff;
      led_in           = led_ff;
      taken_in         = 1'b0;
      if (in_data_ff.cmd == mlk_pkg::CMD_CHAR) begin
         if (phase_ff == PH_IDLE) begin
            taken_in      = 1'b1;
            tick_count_in = '0;
            if (in_data_ff.char_code inside {[mlk_pkg::CHAR_LOW:mlk_pkg::CHAR_HIGH]}) begin
               element_bits_in  = MAX_ELEMENTS'(entry[3:0]);
               elements_left_in = entry[6:4];
               phase_in         = PH_OFF;
            end else begin
               element_bits_in  = '0;
               elements_left_in = 3'd0;
               phase_in         = PH_PAUSE;
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         if (tick_inc < duration) begin
            tick_count_in = tick_inc;
         end else begin
            tick_count_in = '0;
            case (phase_ff)
               PH_OFF: begin
                  led_in   = 1'b1;
                  phase_in = PH_ON;
               end
               PH_ON: begin
                  led_in           = 1'b0;
                  element_bits_in  = element_bits_ff >> 1;
                  elements_left_in = left_dec;
                  phase_in         = (left_dec == 3'd0) ? PH_PAUSE : PH_OFF;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         phase_ff         <= PH_IDLE;
         element_bits_ff  <= '0;
         elements_left_ff <= 3'd0;
         tick_count_ff    <= '0;
         led_ff           <= 1'b0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
            in_data_ff  <= req_data;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff           <= 1'b1;
            out_data_ff.led_on     <= led_in;
            out_data_ff.busy_res   <= (phase_in != PH_IDLE);
            out_data_ff.char_taken <= taken_in;
            phase_ff               <= phase_in;
            element_bits_ff        <= element_bits_in;
            elements_left_ff       <= elements_left_in;
            tick_count_ff          <= tick_count_in;
            led_ff                 <= led_in;
         end else if (rsp_accept) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `MLK_ASSERT(a_led_needs_busy, clock, reset, out_valid_ff && out_data_ff.led_on |-> out_data_ff.busy_res, "led lit while keyer reports idle")
   `MLK_ASSERT(a_taken_busy, clock, reset, out_valid_ff && out_data_ff.char_taken |-> out_data_ff.busy_res, "accepted character left keyer idle")
   `MLK_ASSERT(a_idle_clean, clock, reset, phase_ff == PH_IDLE |-> tick_count_ff == '0 && !led_ff, "idle with running timer or lit led")
   `MLK_ASSERT(a_stall_full, clock, reset, req_stall |-> in_valid_ff && out_valid_ff, "stall raised with room in the pipeline")

endmodule

[sv/morse_letter_keyer.sv]
// top level of the morse letter keyer
//
// morse letter keyer: each req_ transaction is either a one millisecond tick
// (cmd 0) or a received character (cmd 1), and each one gives exactly one
// rsp_ transaction reporting the led level, whether a letter or pause is still
// sending, and whether the character was taken. a lower-case letter a..z is
// keyed as its morse elements, each an off half then an on half of dot_ticks
// or dash_ticks, followed by pause_ticks of silence; any other byte keys only
// the pause, and a character arriving while busy is dropped. the block takes
// one transaction per clock while the result side keeps up: it is held in an
// input register, the keyer state is updated by one short pass of logic, and
// the result lands in an output register. timing registers are written at the
// csr_ port and take effect at once, also in the middle of a letter; write
// them only while no transaction is in flight.
module morse_letter_keyer #(
   // longest letter this build can hold, sets the element shift register
   parameter int unsigned MAX_ELEMENTS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick / character transactions in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mlk_pkg::req_type              req_data,
   // one result transaction per request
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mlk_pkg::rsp_type              rsp_data,
   // timing register writes
   input  logic                          csr_wr_en,
   input  logic [mlk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mlk_pkg::TICK_W-1:0]    csr_wdata
);

   // current dot, dash and pause lengths
   mlk_pkg::cfg_type cfg;

   mlk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // the keyer proper: input register, state, output register
   mlk_core #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/morse_letter_keyer_checker.sv]
// checker for the morse letter keyer: predicts each result transaction and compares it
module morse_letter_keyer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  mlk_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  mlk_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [mlk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mlk_pkg::TICK_W-1:0]    csr_wdata,
   output int                            failures,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {KEY_IDLE, KEY_OFF, KEY_ON, KEY_PAUSE} key_phase_type;

   mlk_pkg::cfg_type           timing;
   logic [3:0]                 pattern;
   logic [2:0]                 remaining;
   key_phase_type              key_phase;
   logic [mlk_pkg::TICK_W-1:0] elapsed;
   logic                       lit;
   mlk_pkg::rsp_type           led_results[$];

   initial failures = 0;

   function automatic string morse_of(input int unsigned letter);
      string code;
      case (letter)
         0:       code = ".-";
         1:       code = "-...";
         2:       code = "-.-.";
         3:       code = "-..";
         4:       code = ".";
         5:       code = "..-.";
         6:       code = "--.";
         7:       code = "....";
         8:       code = "..";
         9:       code = ".---";
         10:      code = "-.-";
         11:      code = ".-..";
         12:      code = "--";
         13:      code = "-.";
         14:      code = "---";
         15:      code = ".--.";
         16:      code = "--.-";
         17:      code = ".-.";
         18:      code = "...";
         19:      code = "-";
         20:      code = "..-";
         21:      code = "...-";
         22:      code = ".--";
         23:      code = "-..-";
         24:      code = "-.--";
         25:      code = "--..";
         default: code = "";
      endcase
      return code;
   endfunction

   // one millisecond of keying
   function automatic void key_tick();
      logic [mlk_pkg::TICK_W-1:0] span;
      if (key_phase == KEY_IDLE) return;
      if (key_phase == KEY_PAUSE) span = timing.pause_ticks;
      else span = pattern[0] ? timing.dash_ticks : timing.dot_ticks;
      elapsed = elapsed + 1'b1;
      if (elapsed < span) return;
      elapsed = '0;
      case (key_phase)
         KEY_OFF: begin
            lit = 1'b1;
            key_phase = KEY_ON;
         end
         KEY_ON: begin
            lit = 1'b0;
            pattern = pattern >> 1;
            if (remaining != 0) remaining = remaining - 1'b1;
            key_phase = (remaining == 0) ? KEY_PAUSE : KEY_OFF;
         end
         default: key_phase = KEY_IDLE;
      endcase
   endfunction

   function automatic mlk_pkg::rsp_type key_step(input mlk_pkg::req_type item);
      mlk_pkg::rsp_type res;
      string            code;
      res.char_taken = 1'b0;
      if (item.cmd == mlk_pkg::CMD_CHAR) begin
         if (key_phase == KEY_IDLE) begin
            res.char_taken = 1'b1;
            elapsed = '0;
            pattern = '0;
            remaining = '0;
            if (item.char_code >= mlk_pkg::CHAR_LOW && item.char_code <= mlk_pkg::CHAR_HIGH) begin
               code = morse_of(32'(item.char_code - mlk_pkg::CHAR_LOW));
               for (int i = 0; i < code.len(); i++) pattern[i] = (code[i] == "-");
               remaining = 3'(code.len());
               key_phase = KEY_OFF;
            end else begin
               key_phase = KEY_PAUSE;
            end
         end
      end else begin
         key_tick();
      end
      res.led_on = lit;
      res.busy_res = (key_phase != KEY_IDLE);
      return res;
   endfunction

   function automatic void check_field(input string field, input logic want, input logic got);
      if (got !== want) begin
         failures++;
         $display("%0t ns: %s expected %0b, got %0b", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      mlk_pkg::rsp_type want;
      if (reset) begin
         timing.dot_ticks   = mlk_pkg::DOT_TICKS_RESET;
         timing.dash_ticks  = mlk_pkg::DASH_TICKS_RESET;
         timing.pause_ticks = mlk_pkg::PAUSE_TICKS_RESET;
         pattern   = '0;
         remaining = '0;
         key_phase = KEY_IDLE;
         elapsed   = '0;
         lit       = 1'b0;
         led_results.delete();
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mlk_pkg::CSR_DOT_TICKS:   timing.dot_ticks = csr_wdata;
               mlk_pkg::CSR_DASH_TICKS:  timing.dash_ticks = csr_wdata;
               mlk_pkg::CSR_PAUSE_TICKS: timing.pause_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (led_results.size() == 0) begin
               failures++;
               $display("%0t ns: no result expected, got led_on %0b busy_res %0b char_taken %0b",
                        $time, rsp_data.led_on, rsp_data.busy_res, rsp_data.char_taken);
            end else begin
               want = led_results.pop_front();
               check_field("led_on", want.led_on, rsp_data.led_on);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("char_taken", want.char_taken, rsp_data.char_taken);
            end
         end
         if (req_valid && !req_stall) led_results.push_back(key_step(req_data));
         pending <= led_results.size();
      end
   end

endmodule

[bench/morse_letter_keyer_test.sv]
// stimulus, clock, reset and verdict for the morse letter keyer bench
module morse_letter_keyer_test;
   timeunit 1ns;
   timeprecision 1ps;

   // index past the last timing register, the keyer must ignore it
   localparam logic [mlk_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int MAX_GAP     = 17;
   localparam int LONG_HOLD   = 300;
   localparam int QUIET_LIMIT = 2000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   mlk_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   mlk_pkg::rsp_type              rsp_data;
   logic                          csr_wr_en;
   logic [mlk_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mlk_pkg::TICK_W-1:0]    csr_wdata;

   int failures;
   int pending;
   int quiet_cycles;

   // calm: neither side idles; hold_request: receiver sits out one long stretch
   bit calm;
   bit hold_request;

   // timing the keyer holds now, mirrored so sequences can be sized to finish
   int cur_dot;
   int cur_dash;
   int cur_pause;

   morse_letter_keyer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   morse_letter_keyer_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycles in which no transaction moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   // watchdog: a hung channel ends the run
   initial begin
      @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // result side: a random hold-off before each transaction, or one long one on request
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD;
         end else if (calm) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, MAX_GAP);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic mlk_pkg::req_type tick_item();
      mlk_pkg::req_type item;
      item.cmd = mlk_pkg::CMD_TICK;
      // byte is ignored on a tick, but it still gets exercised
      item.char_code = 8'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic mlk_pkg::req_type char_item(input logic [mlk_pkg::CHAR_W-1:0] code);
      mlk_pkg::req_type item;
      item.cmd = mlk_pkg::CMD_CHAR;
      item.char_code = code;
      return item;
   endfunction

   // offer one transaction after a random gap and hold it until it is taken
   task automatic offer(input mlk_pkg::req_type item);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // sender goes quiet until every result transaction has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // all three timing registers, then a write to the unused index
   task automatic write_timing(input logic [mlk_pkg::TICK_W-1:0] dot, dash, pause);
      csr_wr_en <= 1'b1;
      csr_index <= mlk_pkg::CSR_DOT_TICKS;
      csr_wdata <= dot;
      @(negedge clock);
      csr_index <= mlk_pkg::CSR_DASH_TICKS;
      csr_wdata <= dash;
      @(negedge clock);
      csr_index <= mlk_pkg::CSR_PAUSE_TICKS;
      csr_wdata <= pause;
      @(negedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 11'($urandom_range(0, 2047));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_dot   = int'(dot);
      cur_dash  = int'(dash);
      cur_pause = int'(pause);
   endtask

   // mostly a character followed by enough ticks to key it out completely,
   // sometimes cut short so the next character lands while busy, plus loose noise
   task automatic run_random(input int count);
      int               sent;
      int               span;
      int               longest;
      int               ticks;
      int               roll;
      mlk_pkg::req_type item;
      longest = (cur_dot > cur_dash) ? cur_dot : cur_dash;
      if (longest == 0) longest = 1;
      span = 8 * longest + ((cur_pause == 0) ? 1 : cur_pause);
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 9);
         if (roll < 8) begin
            if ($urandom_range(0, 3) != 0)
               offer(char_item(8'($urandom_range(mlk_pkg::CHAR_LOW, mlk_pkg::CHAR_HIGH))));
            else
               offer(char_item(8'($urandom_range(0, 255))));
            ticks = (roll == 7) ? $urandom_range(0, span) : span + $urandom_range(0, 2);
            repeat (ticks) offer(tick_item());
            sent += ticks + 1;
         end else begin
            item.cmd = 1'($urandom_range(0, 1));
            item.char_code = 8'($urandom_range(0, 255));
            offer(item);
            sent++;
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      cur_dot      = int'(mlk_pkg::DOT_TICKS_RESET);
      cur_dash     = int'(mlk_pkg::DASH_TICKS_RESET);
      cur_pause    = int'(mlk_pkg::PAUSE_TICKS_RESET);
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset timing: idle tick, a letter taken, another dropped while busy
      offer(tick_item());
      offer(char_item("e"));
      offer(tick_item());
      offer(char_item("q"));
      offer(tick_item());
      drain();

      // zero durations behave as one tick; keyer is still busy from above,
      // so the new values also take effect in the middle of a letter
      write_timing(11'd0, 11'd1, 11'd0);
      repeat (12) offer(tick_item());
      // k must come out dash-dot-dash, z arrives while it is keying
      offer(char_item("k"));
      offer(char_item("z"));
      repeat (7) offer(tick_item());
      // bytes outside a..z key only the pause, upper case included
      offer(char_item(8'h00));
      offer(tick_item());
      offer(char_item(8'hFF));
      offer(tick_item());
      offer(char_item("A"));
      offer(tick_item());
      offer(char_item("a"));
      repeat (5) offer(tick_item());
      drain();

      write_timing(11'd1, 11'd1, 11'd1);
      run_random(80);
      drain();

      // a stretch with no idling on either side
      calm = 1'b1;
      write_timing(11'd0, 11'd0, 11'd0);
      run_random(80);
      drain();
      calm = 1'b0;

      // receiver holds off for a long stretch while transactions keep coming
      write_timing(11'd3, 11'd5, 11'd2);
      hold_request = 1'b1;
      run_random(90);
      drain();

      write_timing(11'($urandom_range(1, 6)), 11'($urandom_range(1, 6)),
                   11'($urandom_range(1, 6)));
      run_random(90);
      drain();

      write_timing(11'($urandom_range(0, 6)), 11'($urandom_range(0, 6)),
                   11'($urandom_range(0, 6)));
      run_random(80);
      drain();

      // longest durations: b starts with a dash that cannot finish here
      write_timing(11'd2047, 11'd2047, 11'd2047);
      offer(char_item("b"));
      repeat (40) offer(tick_item());
      drain();
      // dash cut below the ticks already spent, so the off half ends on the next tick
      write_timing(11'd3, 11'd7, 11'd2);
      run_random(50);
      drain();

      // let any stray result transaction show itself
      repeat (8) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
